[rtl/core/charlieplex_led_frame_scanner_top_macros.svh]
// Assertion macros for the scanner RTL.
// Both forms are clocked on the rising edge and masked while reset is high.
`ifndef CHARLIEPLEX_LED_FRAME_SCANNER_TOP_MACROS_SVH
`define CHARLIEPLEX_LED_FRAME_SCANNER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Check that cond_expr holds at every edge.
`define CLFS_ASSERT_ALWAYS(label, clk, rst, cond_expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond_expr)) \
      else $error("scanner assertion failed");
// Check that cons_expr holds whenever ante_expr holds.
`define CLFS_ASSERT_IMPLIES(label, clk, rst, ante_expr, cons_expr) \
   label: assert property (@(posedge clk) disable iff (rst) (ante_expr) |-> (cons_expr)) \
      else $error("scanner assertion failed");
`else
`define CLFS_ASSERT_ALWAYS(label, clk, rst, cond_expr)
`define CLFS_ASSERT_IMPLIES(label, clk, rst, ante_expr, cons_expr)
`endif

`endif

[rtl/core/clfs_pkg.sv]
`timescale 1ns / 1ps

package clfs_pkg;

   // Fixed field widths of the stream beats
   localparam int FRAME_W      = 54;
   localparam int REPEATS_W    = 16;
   localparam int TICKS_W      = 16;
   localparam int SLOT_W       = 6;
   localparam int OUT_LINES    = 8;
   localparam int LINE_IDX_W   = 4;
   localparam int REQ_DATA_W   = 72;
   localparam int RSP_DATA_W   = 32;

   // Widest supported frame and repeat counter
   localparam int LED_COUNT_MAX   = 56;
   localparam int REPEAT_BITS_MAX = 32;

   // Default configuration
   localparam int DEF_LINE_COUNT  = 8;
   localparam int DEF_LED_COUNT   = 54;
   localparam int DEF_REPEAT_BITS = 16;
   localparam logic [TICKS_W-1:0] SLOT_TICKS_RESET = 16'd128;

   // Command codes carried in req_tuser
   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_TICK = 1'b1
   } cmd_type;

   // Position of the current slot, handed to the line decoder
   typedef struct packed {
      logic                  lit;
      logic [SLOT_W-1:0]     cath;
      logic [LINE_IDX_W-1:0] j;
   } slot_pos_type;

   // Result beat, first field in the highest bits
   typedef struct packed {
      logic [6:0]           pad;
      logic                 accepted;
      logic                 frame_done;
      logic                 busy_res;
      logic [SLOT_W-1:0]    slot;
      logic [OUT_LINES-1:0] line_level;
      logic [OUT_LINES-1:0] line_drive;
   } rsp_beat_type;

endpackage

[rtl/core/charlieplex_led_frame_scanner_top.sv]
`timescale 1ns / 1ps
// Charlieplex LED frame scanner. A load beat (req_tuser = 0) latches a frame
// bitmap and a repeat count and is refused while a scan runs; a repeat count of
// zero reports frame_done at once. Tick beats (req_tuser = 1) advance the dwell
// counter; each LED slot is held csr_wr_data ticks (0 acts as 1), and slot k is
// lit on cathode line k/(LINE_COUNT-1) with the anode on line k mod (LINE_COUNT-1),
// skipping the cathode line. Every request beat produces exactly one response beat
// carrying the state after it. The block takes one beat per clock: all the work sits
// between the state registers and the response register, so the response appears in
// the cycle after the request is accepted, and input stalls only when the response
// register is full and rsp_tready is low.
`include "charlieplex_led_frame_scanner_top_macros.svh"

module charlieplex_led_frame_scanner_top
   import clfs_pkg::*;
#(
   parameter int LINE_COUNT  = DEF_LINE_COUNT,
   parameter int LED_COUNT   = DEF_LED_COUNT,
   parameter int REPEAT_BITS = DEF_REPEAT_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // frame_bits[53:0], repeats[69:54], zero
   input  logic                  req_tuser,  // command
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // line_drive[7:0], line_level[15:8],
                                             // slot[21:16], busy_res[22],
                                             // frame_done[23], accepted[24], zero
   // configuration
   input  logic                  csr_wr_en,
   input  logic [TICKS_W-1:0]    csr_wr_data  // slot_ticks
);

   localparam int SLOT_IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam logic [SLOT_W-1:0]     SLOT_LAST = SLOT_W'(LED_COUNT - 1);
   localparam logic [LINE_IDX_W-1:0] J_LAST    = LINE_IDX_W'(LINE_COUNT - 2);

   // State registers
   logic [LED_COUNT-1:0]   frame_ff, frame_in;
   logic [REPEAT_BITS-1:0] scans_ff, scans_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [SLOT_W-1:0]      cath_ff, cath_in;
   logic [LINE_IDX_W-1:0]  j_ff, j_in;
   logic [TICKS_W-1:0]     dwell_ff, dwell_in;
   logic                   running_ff, running_in;
   logic [TICKS_W-1:0]     slot_ticks_ff;

   // Response register
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   rsp_beat_type           rsp_beat_ff, rsp_beat_in;

   logic                   accept;
   cmd_type                cmd;
   logic [LED_COUNT_MAX-1:0]   frame_ext;
   logic [REPEAT_BITS_MAX-1:0] repeats_ext;
   logic [TICKS_W-1:0]     limit;
   logic [TICKS_W:0]       dwell_sum;
   logic                   done;
   logic                   acc;
   slot_pos_type           pos;
   logic [OUT_LINES-1:0]   line_drive;
   logic [OUT_LINES-1:0]   line_level;

   // Accept a beat whenever the response register is free or draining
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign cmd        = cmd_type'(req_tuser);

   assign frame_ext   = {{(LED_COUNT_MAX-FRAME_W){1'b0}}, req_tdata[FRAME_W-1:0]};
   assign repeats_ext = {{(REPEAT_BITS_MAX-REPEATS_W){1'b0}},
                         req_tdata[FRAME_W+REPEATS_W-1:FRAME_W]};

   assign limit     = (slot_ticks_ff == '0) ? TICKS_W'(1) : slot_ticks_ff;
   assign dwell_sum = {1'b0, dwell_ff} + 1'b1;

   // Advance the scan state for one beat
   always_comb begin
      frame_in   = frame_ff;
      scans_in   = scans_ff;
      slot_in    = slot_ff;
      cath_in    = cath_ff;
      j_in       = j_ff;
      dwell_in   = dwell_ff;
      running_in = running_ff;
      done       = 1'b0;
      acc        = 1'b0;
      if (accept) begin
         case (cmd)
            CMD_LOAD: begin
               if (!running_ff) begin
                  acc      = 1'b1;
                  frame_in = frame_ext[LED_COUNT-1:0];
                  scans_in = repeats_ext[REPEAT_BITS-1:0];
                  slot_in  = '0;
                  cath_in  = '0;
                  j_in     = '0;
                  dwell_in = '0;
                  if (repeats_ext[REPEAT_BITS-1:0] == '0) begin
                     done = 1'b1;
                  end else begin
                     running_in = 1'b1;
                  end
               end
            end
            CMD_TICK: begin
               if (running_ff) begin
                  if (dwell_sum >= {1'b0, limit}) begin
                     dwell_in = '0;
                     if (slot_ff == SLOT_LAST) begin
                        slot_in  = '0;
                        cath_in  = '0;
                        j_in     = '0;
                        scans_in = scans_ff - 1'b1;
                        if (scans_ff == REPEAT_BITS'(1)) begin
                           running_in = 1'b0;
                           done       = 1'b1;
                        end
                     end else begin
                        slot_in = slot_ff + 1'b1;
                        if (j_ff == J_LAST) begin
                           j_in    = '0;
                           cath_in = cath_ff + 1'b1;
                        end else begin
                           j_in = j_ff + 1'b1;
                        end
                     end
                  end else begin
                     dwell_in = dwell_sum[TICKS_W-1:0];
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Look up the lit bit of the slot shown after this beat
   always_comb begin
      pos.lit  = running_in && frame_in[slot_in[SLOT_IDX_W-1:0]];
      pos.cath = cath_in;
      pos.j    = j_in;
   end

   clfs_line_dec #(
      .LINE_COUNT (LINE_COUNT)
   ) u_line_dec (
      .pos        (pos),
      .line_drive (line_drive),
      .line_level (line_level)
   );

   // Build the response beat
   always_comb begin
      rsp_beat_in            = '0;
      rsp_beat_in.line_drive = line_drive;
      rsp_beat_in.line_level = line_level;
      rsp_beat_in.slot       = slot_in;
      rsp_beat_in.busy_res   = running_in;
      rsp_beat_in.frame_done = done;
      rsp_beat_in.accepted   = acc;
   end

   // Hold the response until taken, load on every accepted beat
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (accept) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   // Scan state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff      <= '0;
         scans_ff      <= '0;
         slot_ff       <= '0;
         cath_ff       <= '0;
         j_ff          <= '0;
         dwell_ff      <= '0;
         running_ff    <= 1'b0;
         slot_ticks_ff <= SLOT_TICKS_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         frame_ff      <= frame_in;
         scans_ff      <= scans_in;
         slot_ff       <= slot_in;
         cath_ff       <= cath_in;
         j_ff          <= j_in;
         dwell_ff      <= dwell_in;
         running_ff    <= running_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_wr_en) begin
            slot_ticks_ff <= csr_wr_data;
         end
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_beat_ff <= rsp_beat_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_beat_ff;

   // A running scan always has scans left and stays inside the frame
   `CLFS_ASSERT_IMPLIES(a_run_has_scans, clock, reset, running_ff, scans_ff != '0)
   `CLFS_ASSERT_IMPLIES(a_run_slot_range, clock, reset, running_ff, slot_ff <= SLOT_LAST)
   // Idle scanner parks at slot zero with a cleared counter
   `CLFS_ASSERT_IMPLIES(a_idle_parked, clock, reset, !running_ff,
      (slot_ff == '0) && (dwell_ff == '0) && (cath_ff == '0) && (j_ff == '0))
   // A finished frame never reports busy on the same beat
   `CLFS_ASSERT_IMPLIES(a_done_not_busy, clock, reset,
      rsp_tvalid_ff && rsp_beat_ff.frame_done, !rsp_beat_ff.busy_res)
   // Lines only drive while busy
   `CLFS_ASSERT_IMPLIES(a_idle_floats, clock, reset,
      rsp_tvalid_ff && !rsp_beat_ff.busy_res, rsp_beat_ff.line_drive == '0)

endmodule

[rtl/core/clfs_line_dec.sv]
`timescale 1ns / 1ps

module clfs_line_dec
   import clfs_pkg::*;
#(
   parameter int LINE_COUNT = DEF_LINE_COUNT
) (
   input  slot_pos_type         pos,
   output logic [OUT_LINES-1:0] line_drive,
   output logic [OUT_LINES-1:0] line_level
);

   logic [LINE_IDX_W-1:0] anode;

   // Skip the cathode line when picking the anode
   always_comb begin
      if ({{(SLOT_W-LINE_IDX_W){1'b0}}, pos.j} < pos.cath) begin
         anode = pos.j;
      end else begin
         anode = pos.j + 1'b1;
      end
   end

   // Drive cathode low and anode high on lines that exist
   always_comb begin
      for (int i = 0; i < OUT_LINES; i++) begin
         line_drive[i] = 1'b0;
         line_level[i] = 1'b0;
         if (pos.lit && (i < LINE_COUNT)) begin
            if (pos.cath == SLOT_W'(i)) begin
               line_drive[i] = 1'b1;
            end
            if (anode == LINE_IDX_W'(i)) begin
               line_drive[i] = 1'b1;
               line_level[i] = 1'b1;
            end
         end
      end
   end

endmodule
